>>> rtl/core/crdf_pkg.sv
// Shared types, constants and helper functions of the CRC-framed request deframer.
package crdf_pkg;

    localparam int FRAME_BYTES    = 24;
    localparam int CRC_BYTES      = 20;
    localparam int MAX_PAYLOAD    = 4096;
    localparam int FILL_W         = 5;
    localparam int LEN_W          = 13;

    localparam logic [12:0] REPLY_OVERHEAD = 13'd28;
    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
    localparam logic [31:0] CNT_MAX        = 32'hFFFF_FFFF;
    localparam logic [7:0]  MAGIC_0        = 8'h4D;
    localparam logic [7:0]  MAGIC_1        = 8'h33;
    localparam logic [7:0]  MAGIC_2        = 8'h52;
    localparam logic [7:0]  MAGIC_3        = 8'h51;
    localparam logic [15:0] FRAME_VERSION  = 16'd1;

    // Register reset values.
    localparam logic [15:0] SNAP_OP_RST    = 16'd1;
    localparam logic [15:0] FLASH_OP_RST   = 16'd2;
    localparam logic [12:0] LIMIT_RST      = 13'd256;
    localparam logic [15:0] TIMEOUT_RST    = 16'd500;
    localparam logic [24:0] FLASH_SIZE_RST = 25'h100_0000;
    localparam logic [1:0]  SRC_EN_RST     = 2'b11;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_OP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_OP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_SIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_EN     = 3'd5;

    localparam logic [1:0] KIND_BAD   = 2'd0;
    localparam logic [1:0] KIND_SNAP  = 2'd1;
    localparam logic [1:0] KIND_FLASH = 2'd2;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_SENT  = 2'd2,
        OP_ABORT = 2'd3
    } crdf_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_CHECK
    } crdf_state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
        logic [12:0] sent_count;
    } crdf_in_t;

    typedef struct packed {
        logic        accepted;
        logic        frame_done;
        logic [1:0]  read_kind;
        logic [31:0] request_id;
        logic [31:0] read_address;
        logic [12:0] read_length;
        logic [15:0] op_code;
        logic [12:0] pending_bytes;
        logic [31:0] request_total;
        logic [31:0] bad_request_total;
        logic [31:0] timeout_total;
    } crdf_out_t;

    typedef struct packed {
        logic load;
        logic shift;
    } crdf_cell_ctl_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    // One byte of the reflected CRC-32, bit by bit.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc32_byte = c;
    endfunction

endpackage

>>> rtl/core/crdf_cell.sv
// One byte cell of the frame window chain.
module crdf_cell (
    input  logic                    aclk,
    input  crdf_pkg::crdf_cell_ctl_t ctl,
    input  logic [7:0]              load_byte,
    input  logic [7:0]              right_byte,
    output logic [7:0]              byte_q
);
    import crdf_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // A slide takes the neighbor's byte; a load takes the incoming byte.
    always_comb begin
        byte_next = byte_reg;
        if (ctl.shift) begin
            byte_next = right_byte;
        end else if (ctl.load) begin
            byte_next = load_byte;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;

endmodule

>>> rtl/core/crdf_crc.sv
// Iterative CRC-32 unit that folds in one byte per cycle while step_en is high.
module crdf_crc (
    input  logic        aclk,
    input  logic        init,
    input  logic        step_en,
    input  logic [7:0]  data_byte,
    output logic [31:0] crc_q
);
    import crdf_pkg::*;

    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    always_comb begin
        crc_next = crc_reg;
        if (init) begin
            crc_next = CRC_INIT;
        end else if (step_en) begin
            crc_next = crc32_byte(crc_reg, data_byte);
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
    end

    assign crc_q = crc_reg;

endmodule

>>> rtl/core/crc_framed_request_deframer_core.sv
// Top level of the CRC-framed request deframer: window chain, CRC pass and request decode.
//
// Usage: items arrive on s_valid/s_ready/s_data, each an operation (received byte,
// time tick, reply bytes sent, abort) with its byte, time and sent count. Every item
// yields exactly one result on m_valid/m_ready/m_data.
// An item that does not complete the 24-byte window is answered in the cycle after
// acceptance. The byte that fills the window starts a CRC pass over the first
// 20 window bytes, one byte per cycle through the CRC unit, followed by the ST_CHECK
// decode state, which loads that item's result into the output register.
// Flow control: one item is in flight at a time; s_ready is high only while no item
// is at work and the output register is empty, so a new item is taken only after
// the result of the last one has been delivered.
// Reset (aresetn low at a clock edge) restores the register defaults, empties the
// window, clears any pending reply and zeroes the saturating counters.
// When the receiver stalls, the result holds in the output register and no new
// item is taken until it has been delivered.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wr_data while idle.
module crc_framed_request_deframer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  crdf_pkg::crdf_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output crdf_pkg::crdf_out_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [crdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [crdf_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import crdf_pkg::*;

    localparam logic [FILL_W-1:0] LAST_SLOT = FILL_W'(FRAME_BYTES - 1);
    localparam logic [FILL_W-1:0] LAST_CRC  = FILL_W'(CRC_BYTES - 1);
    localparam logic [16:0]       MAX_P     = 17'(MAX_PAYLOAD);

    // Configuration registers.
    logic [15:0] snap_op_reg;
    logic [15:0] flash_op_reg;
    logic [12:0] limit_reg;
    logic [15:0] timeout_reg;
    logic [24:0] flash_size_reg;
    logic [1:0]  src_en_reg;

    // Control state.
    crdf_state_t       state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] crc_idx_reg, crc_idx_next;
    logic [31:0]       last_time_reg, last_time_next;
    logic [12:0]       reply_size_reg, reply_size_next;
    logic [12:0]       reply_sent_reg, reply_sent_next;
    logic [31:0]       req_cnt_reg, req_cnt_next;
    logic [31:0]       bad_cnt_reg, bad_cnt_next;
    logic [31:0]       tmo_cnt_reg, tmo_cnt_next;
    logic              m_valid_reg, m_valid_next;
    crdf_out_t         m_data_reg, m_data_next;

    logic        s_accept;
    logic        out_load;
    logic        idle_drop;
    logic [FILL_W-1:0] fill_base;
    logic [12:0] pending;
    logic        byte_taken;
    logic        window_full;
    logic        slide;

    logic [7:0]     win [FRAME_BYTES];
    logic [7:0]     right_nb [FRAME_BYTES];
    crdf_cell_ctl_t cell_ctl [FRAME_BYTES];

    logic [31:0] crc_q;
    logic        crc_init;
    logic        crc_step;

    // Decode of a full window.
    logic        magic_ok, crc_ok, frame_ok;
    logic [15:0] ver, opc;
    logic [31:0] rid, addr, len, crc_rx;
    logic [12:0] lim;
    logic        snap_ok, flash_ok;
    logic [32:0] addr_end;
    logic [1:0]  kind;
    logic [12:0] glen;

    assign s_ready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // A byte or tick first drops a stale partial frame.
    assign idle_drop = (fill_reg != '0) &&
                       ((s_data.now_ms - last_time_reg) > {16'd0, timeout_reg});
    assign fill_base = idle_drop ? '0 : fill_reg;
    assign pending   = reply_size_reg - reply_sent_reg;

    assign byte_taken  = s_accept && (crdf_op_t'(s_data.operation) == OP_BYTE) &&
                         (reply_size_reg == '0);
    assign window_full = byte_taken && (fill_base == LAST_SLOT);

    // The window chain: each cell holds one byte and can take its right neighbor's.
    for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
        if (i == FRAME_BYTES - 1) begin : g_tail
            assign right_nb[i] = 8'd0;
        end else begin : g_body
            assign right_nb[i] = win[i+1];
        end
        assign cell_ctl[i].load  = byte_taken && (fill_base == FILL_W'(i));
        assign cell_ctl[i].shift = slide;
        crdf_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl[i]),
            .load_byte  (s_data.data_byte),
            .right_byte (right_nb[i]),
            .byte_q     (win[i])
        );
    end

    assign crc_init = window_full;
    assign crc_step = (state_reg == ST_CRC);

    crdf_crc u_crc (
        .aclk      (aclk),
        .init      (crc_init),
        .step_en   (crc_step),
        .data_byte (win[crc_idx_reg]),
        .crc_q     (crc_q)
    );

    // Field extraction and request checks, used in the decode cycle.
    always_comb begin
        magic_ok = (win[0] == MAGIC_0) && (win[1] == MAGIC_1) &&
                   (win[2] == MAGIC_2) && (win[3] == MAGIC_3);
        crc_rx   = {win[23], win[22], win[21], win[20]};
        crc_ok   = (crc_rx == ~crc_q);
        frame_ok = magic_ok && crc_ok;
        ver      = {win[5], win[4]};
        opc      = {win[7], win[6]};
        rid      = {win[11], win[10], win[9], win[8]};
        addr     = {win[15], win[14], win[13], win[12]};
        len      = {win[19], win[18], win[17], win[16]};
        lim      = ({4'd0, limit_reg} > MAX_P) ? MAX_P[12:0] : limit_reg;
        addr_end = {1'b0, addr} + {1'b0, len};
        snap_ok  = (ver == FRAME_VERSION) && (opc == snap_op_reg) && (addr == '0) &&
                   (len == {19'd0, lim}) && src_en_reg[0];
        flash_ok = (ver == FRAME_VERSION) && (opc == flash_op_reg) && (len != '0) &&
                   (len <= {19'd0, lim}) && (addr <= {7'd0, flash_size_reg}) &&
                   (addr_end <= {8'd0, flash_size_reg}) && src_en_reg[1];
        if (snap_ok) begin
            kind = KIND_SNAP;
        end else if (flash_ok) begin
            kind = KIND_FLASH;
        end else begin
            kind = KIND_BAD;
        end
        glen = (kind == KIND_BAD) ? 13'd0 : len[12:0];
    end

    assign slide = (state_reg == ST_CHECK) && !frame_ok;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (window_full) begin
                    state_next = ST_CRC;
                end
            end
            ST_CRC: begin
                if (crc_idx_reg == LAST_CRC) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result register updates.
    always_comb begin
        fill_next       = fill_reg;
        crc_idx_next    = crc_idx_reg;
        last_time_next  = last_time_reg;
        reply_size_next = reply_size_reg;
        reply_sent_next = reply_sent_reg;
        req_cnt_next    = req_cnt_reg;
        bad_cnt_next    = bad_cnt_reg;
        tmo_cnt_next    = tmo_cnt_reg;
        out_load        = 1'b0;
        m_data_next     = m_data_reg;
        m_data_next.accepted     = 1'b1;
        m_data_next.frame_done   = 1'b0;
        m_data_next.read_kind    = KIND_BAD;
        m_data_next.request_id   = '0;
        m_data_next.read_address = '0;
        m_data_next.read_length  = '0;
        m_data_next.op_code      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    out_load = !window_full;
                    case (crdf_op_t'(s_data.operation))
                        OP_BYTE: begin
                            if (reply_size_reg != '0) begin
                                m_data_next.accepted = 1'b0;
                            end else begin
                                if (idle_drop) begin
                                    tmo_cnt_next = sat_inc(tmo_cnt_reg);
                                end
                                last_time_next = s_data.now_ms;
                                fill_next      = fill_base + FILL_W'(1);
                                crc_idx_next   = '0;
                            end
                        end
                        OP_TICK: begin
                            if (idle_drop) begin
                                fill_next    = '0;
                                tmo_cnt_next = sat_inc(tmo_cnt_reg);
                            end
                        end
                        OP_SENT: begin
                            if (s_data.sent_count > pending) begin
                                m_data_next.accepted = 1'b0;
                            end else if (s_data.sent_count == pending) begin
                                reply_size_next = '0;
                                reply_sent_next = '0;
                            end else begin
                                reply_sent_next = reply_sent_reg + s_data.sent_count;
                            end
                        end
                        OP_ABORT: begin
                            fill_next       = '0;
                            reply_size_next = '0;
                            reply_sent_next = '0;
                        end
                        default: begin
                            fill_next = fill_reg;
                        end
                    endcase
                end
            end
            ST_CRC: begin
                crc_idx_next = crc_idx_reg + FILL_W'(1);
            end
            ST_CHECK: begin
                out_load = 1'b1;
                if (frame_ok) begin
                    m_data_next.frame_done   = 1'b1;
                    m_data_next.read_kind    = kind;
                    m_data_next.request_id   = rid;
                    m_data_next.read_address = addr;
                    m_data_next.read_length  = glen;
                    m_data_next.op_code      = opc;
                    req_cnt_next    = sat_inc(req_cnt_reg);
                    if (kind == KIND_BAD) begin
                        bad_cnt_next = sat_inc(bad_cnt_reg);
                    end
                    fill_next       = '0;
                    reply_sent_next = '0;
                    reply_size_next = REPLY_OVERHEAD + glen;
                end else begin
                    bad_cnt_next = sat_inc(bad_cnt_reg);
                    fill_next    = LAST_SLOT;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase

        m_data_next.pending_bytes     = reply_size_next - reply_sent_next;
        m_data_next.request_total     = req_cnt_next;
        m_data_next.bad_request_total = bad_cnt_next;
        m_data_next.timeout_total     = tmo_cnt_next;

        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            crc_idx_reg    <= '0;
            last_time_reg  <= '0;
            reply_size_reg <= '0;
            reply_sent_reg <= '0;
            req_cnt_reg    <= '0;
            bad_cnt_reg    <= '0;
            tmo_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            crc_idx_reg    <= crc_idx_next;
            last_time_reg  <= last_time_next;
            reply_size_reg <= reply_size_next;
            reply_sent_reg <= reply_sent_next;
            req_cnt_reg    <= req_cnt_next;
            bad_cnt_reg    <= bad_cnt_next;
            tmo_cnt_reg    <= tmo_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // The result payload needs no reset; it is only read with m_valid.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_op_reg    <= SNAP_OP_RST;
            flash_op_reg   <= FLASH_OP_RST;
            limit_reg      <= LIMIT_RST;
            timeout_reg    <= TIMEOUT_RST;
            flash_size_reg <= FLASH_SIZE_RST;
            src_en_reg     <= SRC_EN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SNAP_OP:    snap_op_reg    <= cfg_wr_data[15:0];
                CFG_FLASH_OP:   flash_op_reg   <= cfg_wr_data[15:0];
                CFG_LIMIT:      limit_reg      <= cfg_wr_data[12:0];
                CFG_TIMEOUT:    timeout_reg    <= cfg_wr_data[15:0];
                CFG_FLASH_SIZE: flash_size_reg <= cfg_wr_data[24:0];
                CFG_SRC_EN:     src_en_reg     <= cfg_wr_data[1:0];
                default: begin
                    src_en_reg <= src_en_reg;
                end
            endcase
        end
    end

    // The window is full for the whole CRC pass and decode cycle.
    a_full_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (fill_reg == FILL_W'(FRAME_BYTES)))
        else $error("window not full during CRC pass");

    // At rest the window never holds a complete frame.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (fill_reg < FILL_W'(FRAME_BYTES)))
        else $error("fill count out of range");

    // The CRC index stays inside the checked bytes.
    a_crc_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CRC) |-> (crc_idx_reg <= LAST_CRC))
        else $error("CRC index past checked bytes");

    // Acknowledged bytes never exceed the reply size.
    a_reply_order: assert property (@(posedge aclk) disable iff (!aresetn)
        reply_sent_reg <= reply_size_reg)
        else $error("reply sent count exceeds reply size");

    // Bytes are only taken into the window while no reply is pending.
    a_no_byte_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (reply_size_reg != '0) |-> !byte_taken)
        else $error("byte stored while a reply is pending");

endmodule
